// ===== hdl/lpfr_pkg.sv =====
package lpfr_pkg;

    localparam logic [7:0] DELIM = 8'h7E;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;

    localparam logic [1:0] CMD_ARM  = 2'd0;
    localparam logic [1:0] CMD_BYTE = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    localparam logic [2:0] ST_BYTE    = 3'd0;
    localparam logic [2:0] ST_DONE    = 3'd1;
    localparam logic [2:0] ST_DROP    = 3'd2;
    localparam logic [2:0] ST_TIMEOUT = 3'd3;
    localparam logic [2:0] ST_SMALL   = 3'd4;

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_HUNT     = 6'b000010,
        PH_LEN_HI   = 6'b000100,
        PH_LEN_LO   = 6'b001000,
        PH_PAYLOAD  = 6'b010000,
        PH_WAIT_END = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  rx_byte;
        logic [31:0] arm_timeout;
        logic [15:0] arm_capacity;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic [15:0] frame_length;
    } t_out_word;

    typedef struct packed {
        logic      valid;
        t_out_word word;
    } t_res;

endpackage

// ===== hdl/lpfr_if.sv =====
interface lpfr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [7:0]  rx_byte;
    logic [31:0] arm_timeout;
    logic [15:0] arm_capacity;

    modport source (output valid, cmd, rx_byte, arm_timeout, arm_capacity, input ready);
    modport sink (input valid, cmd, rx_byte, arm_timeout, arm_capacity, output ready);
endinterface

interface lpfr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic [15:0] frame_length;

    modport source (output valid, status, payload_byte, byte_index, frame_length, input ready);
    modport sink (input valid, status, payload_byte, byte_index, frame_length, output ready);
endinterface

// ===== hdl/lpfr_in_reg.sv =====
module lpfr_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lpfr_in_if.sink           i_rx,
    input  logic              i_take,
    output logic              o_valid,
    output lpfr_pkg::t_in_word o_word
);
    import lpfr_pkg::*;

    logic     r_valid;
    t_in_word r_word;

    assign i_rx.ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_word     = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
    end

    // hold the word until the core takes it
    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_word.cmd          <= i_rx.cmd;
            r_word.rx_byte      <= i_rx.rx_byte;
            r_word.arm_timeout  <= i_rx.arm_timeout;
            r_word.arm_capacity <= i_rx.arm_capacity;
        end
    end
endmodule

// ===== hdl/lpfr_core.sv =====
module lpfr_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_take,
    input  lpfr_pkg::t_in_word i_word,
    output lpfr_pkg::t_res     o_res
);
    import lpfr_pkg::*;

    logic [15:0] r_max_payload;
    t_phase      r_phase, n_phase;
    logic [15:0] r_length, n_length;
    logic [15:0] r_count, n_count;
    logic [31:0] r_ticks, n_ticks;
    logic [15:0] r_capacity, n_capacity;

    logic [15:0] len_full;
    logic [15:0] count_inc;
    logic [31:0] ticks_dec;

    assign len_full  = {r_length[15:8], i_word.rx_byte};
    assign count_inc = r_count + 16'd1;
    assign ticks_dec = (r_ticks != 32'd0) ? (r_ticks - 32'd1) : 32'd0;

    always_comb begin
        n_phase    = r_phase;
        n_length   = r_length;
        n_count    = r_count;
        n_ticks    = r_ticks;
        n_capacity = r_capacity;
        o_res      = '0;

        if (i_word.cmd == CMD_ARM) begin
            n_ticks    = i_word.arm_timeout;
            n_capacity = i_word.arm_capacity;
            n_length   = '0;
            n_count    = '0;
            if (i_word.arm_timeout == 32'd0) begin
                n_phase             = PH_IDLE;
                o_res.valid         = 1'b1;
                o_res.word.status   = ST_TIMEOUT;
            end else begin
                n_phase = PH_HUNT;
            end
        end else if (r_phase != PH_IDLE && i_word.cmd == CMD_BYTE) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_word.rx_byte == DELIM) begin
                        n_phase = PH_LEN_HI;
                    end
                end
                PH_LEN_HI: begin
                    n_length = {i_word.rx_byte, 8'd0};
                    n_phase  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_length = len_full;
                    if (len_full == 16'd0 || len_full > r_max_payload) begin
                        n_phase = PH_HUNT;
                    end else if (len_full > r_capacity) begin
                        n_phase                 = PH_IDLE;
                        o_res.valid             = 1'b1;
                        o_res.word.status       = ST_SMALL;
                        o_res.word.frame_length = len_full;
                    end else begin
                        n_count = '0;
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    n_count = count_inc;
                    if (count_inc >= r_length) begin
                        n_phase = PH_WAIT_END;
                    end
                    o_res.valid             = 1'b1;
                    o_res.word.status       = ST_BYTE;
                    o_res.word.payload_byte = i_word.rx_byte;
                    o_res.word.byte_index   = r_count;
                end
                PH_WAIT_END: begin
                    o_res.valid = 1'b1;
                    if (i_word.rx_byte == DELIM) begin
                        n_phase                 = PH_IDLE;
                        o_res.word.status       = ST_DONE;
                        o_res.word.frame_length = r_length;
                    end else begin
                        n_phase           = PH_HUNT;
                        o_res.word.status = ST_DROP;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end else if (r_phase != PH_IDLE && i_word.cmd == CMD_TICK) begin
            n_ticks = ticks_dec;
            if (ticks_dec == 32'd0) begin
                n_phase           = PH_IDLE;
                o_res.valid       = 1'b1;
                o_res.word.status = ST_TIMEOUT;
            end
        end

        if (!i_take) begin
            o_res.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RESET;
            r_phase       <= PH_IDLE;
            r_length      <= '0;
            r_count       <= '0;
            r_ticks       <= '0;
            r_capacity    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_max_payload <= i_cfg_data;
            end
            if (i_take) begin
                r_phase    <= n_phase;
                r_length   <= n_length;
                r_count    <= n_count;
                r_ticks    <= n_ticks;
                r_capacity <= n_capacity;
            end
        end
    end
endmodule

// ===== hdl/lpfr_out_reg.sv =====
module lpfr_out_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lpfr_pkg::t_res i_res,
    output logic           o_up_ready,
    lpfr_out_if.source     o_res
);
    import lpfr_pkg::*;

    logic      r_valid;
    t_out_word r_word;

    assign o_up_ready         = !r_valid || o_res.ready;
    assign o_res.valid        = r_valid;
    assign o_res.status       = r_word.status;
    assign o_res.payload_byte = r_word.payload_byte;
    assign o_res.byte_index   = r_word.byte_index;
    assign o_res.frame_length = r_word.frame_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_up_ready) begin
            r_valid <= i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_up_ready && i_res.valid) begin
            r_word <= i_res.word;
        end
    end
endmodule

// ===== hdl/length_prefixed_frame_receiver_top.sv =====
// Length-prefixed frame receiver: takes one word per cycle (arm, received byte or
// millisecond tick) and gives at most one result word per input word, registered
// when the core takes the input word. Sustained rate is one word
// per clock, set by the combinational parser step between the input and result
// registers. When the result side stalls, the input stalls once the result register
// and the input register both hold a word. Results are streamed payload bytes with
// their index, then frame complete, frame dropped, timeout or buffer too small.
// Write max_payload only while no word is in flight.
module length_prefixed_frame_receiver_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    lpfr_in_if.sink     i_rx,
    lpfr_out_if.source  o_res
);
    import lpfr_pkg::*;

    logic     in_valid;
    t_in_word in_word;
    logic     up_ready;
    logic     take;
    t_res     res;

    assign take = in_valid && up_ready;

    lpfr_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_take  (take),
        .o_valid (in_valid),
        .o_word  (in_word)
    );

    lpfr_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_take     (take),
        .i_word     (in_word),
        .o_res      (res)
    );

    lpfr_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res      (res),
        .o_up_ready (up_ready),
        .o_res      (o_res)
    );
endmodule
